>>> hdl/wiegand_card_access_table_macros.svh
// Assertion helpers used by the table sequencer RTL.
`ifndef WIEGAND_CARD_ACCESS_TABLE_MACROS_SVH
`define WIEGAND_CARD_ACCESS_TABLE_MACROS_SVH

// The condition must hold at every rising clock edge outside reset.
`define WCT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the cycle after it.
`define WCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/wct_pkg.sv
package wct_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_W = 24;

	localparam logic [4:0] LAST_BIT = 5'd25;
	localparam logic [4:0] FIRST_HALF_END = 5'd12;
	localparam logic [4:0] NUMBER_START = 5'd9;

	typedef enum logic [1:0] {
		CMD_DATA0 = 2'd0,
		CMD_DATA1 = 2'd1,
		CMD_ARM = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		EV_GRANTED = 3'd0,
		EV_DENIED = 3'd1,
		EV_ENROLLED = 3'd2,
		EV_REFUSED = 3'd3,
		EV_DELETED = 3'd4,
		EV_DEL_IGNORED = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		OP_ARM,
		OP_FRAME,
		OP_DELETE
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] delete_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] facility_code;
		logic [15:0] card_number;
		logic parity_error;
		logic [3:0] slot;
		logic [4:0] entry_count;
	} evt_t;

	typedef struct packed {
		logic done;
		logic [KEY_W-1:0] key;
		logic perr;
	} frame_t;

	typedef struct packed {
		logic go;
		op_kind_t kind;
		logic [KEY_W-1:0] key;
		logic perr;
		logic [3:0] del_idx;
	} op_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

endpackage

>>> hdl/wct_frame_rx.sv
module wct_frame_rx (
	input logic clk,
	input logic arst_n,
	input logic pulse,
	input logic bit_in,
	output wct_pkg::frame_t frame
);
	import wct_pkg::*;

	logic [4:0] pos_q;
	logic [7:0] fac_q;
	logic [15:0] num_q;
	logic lead_q;
	logic ones1_q;
	logic ones2_q;
	logic last;

	assign last = (pos_q == LAST_BIT);

	always_comb begin
		frame.done = pulse && last;
		frame.key = {fac_q, num_q};
		frame.perr = (lead_q ^ ones1_q) | ~(ones2_q ^ bit_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fac_q <= '0;
			num_q <= '0;
			lead_q <= 1'b0;
			ones1_q <= 1'b0;
			ones2_q <= 1'b0;
		end else if (pulse) begin
			if (last) begin
				pos_q <= '0;
				fac_q <= '0;
				num_q <= '0;
				lead_q <= 1'b0;
				ones1_q <= 1'b0;
				ones2_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 5'd1;
				if (pos_q == 5'd0) begin
					lead_q <= bit_in;
				end else if (pos_q < NUMBER_START) begin
					fac_q <= {fac_q[6:0], bit_in};
					ones1_q <= ones1_q ^ bit_in;
				end else begin
					num_q <= {num_q[14:0], bit_in};
					if (pos_q <= FIRST_HALF_END) begin
						ones1_q <= ones1_q ^ bit_in;
					end else begin
						ones2_q <= ones2_q ^ bit_in;
					end
				end
			end
		end
	end

endmodule

>>> hdl/wct_table_seq.sv
`include "wiegand_card_access_table_macros.svh"

module wct_table_seq #(
	parameter int TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input wct_pkg::op_t op,
	input logic res_free,
	output wct_pkg::seq_stat_t stat,
	output wct_pkg::evt_t res
);
	import wct_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic armed_q, armed_d;
	logic cmp_vld_q, cmp_vld_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [IDX_W-1:0] del_q, del_d;
	evt_t res_q, res_d;
	logic [KEY_W-1:0] rd_q;

	logic [KEY_W-1:0] mem [TABLE_DEPTH];
	logic we;
	logic re;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	logic [KEY_W-1:0] wdata;
	logic issue;
	logic hit;
	logic [CMP_W-1:0] del_ext;
	logic perr_q, perr_d;

	function automatic evt_t make_evt(event_t ev, logic [KEY_W-1:0] key, logic perr,
			logic [3:0] slot, logic [4:0] cnt);
		evt_t e;
		e.event_res = ev;
		e.facility_code = key[23:16];
		e.card_number = key[15:0];
		e.parity_error = perr;
		e.slot = slot;
		e.entry_count = cnt;
		return e;
	endfunction

	assign issue = (idx_q < count_q);
	assign hit = cmp_vld_q && (rd_q == key_q);
	assign del_ext = CMP_W'(op.del_idx);
	assign raddr = idx_q[IDX_W-1:0];
	assign re = issue && ((state_q == ST_SEARCH) || (state_q == ST_SHIFT));

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		armed_d = armed_q;
		cmp_vld_d = 1'b0;
		cmp_idx_d = cmp_idx_q;
		key_d = key_q;
		perr_d = perr_q;
		del_d = del_q;
		res_d = res_q;
		we = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = op.key;
		stat.idle = (state_q == ST_IDLE);
		stat.res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (op.go) begin
					case (op.kind)
						OP_ARM: begin
							armed_d = 1'b1;
						end
						OP_FRAME: begin
							key_d = op.key;
							perr_d = op.perr;
							if (armed_q) begin
								armed_d = 1'b0;
								state_d = ST_FINISH;
								if (count_q < CNT_W'(TABLE_DEPTH)) begin
									we = 1'b1;
									count_d = CNT_W'(count_q + 1'b1);
									res_d = make_evt(EV_ENROLLED, op.key, op.perr,
										4'(count_q), 5'(count_d));
								end else begin
									res_d = make_evt(EV_REFUSED, op.key, op.perr,
										4'd0, 5'(count_q));
								end
							end else begin
								idx_d = '0;
								state_d = ST_SEARCH;
							end
						end
						OP_DELETE: begin
							if (del_ext < CMP_W'(count_q)) begin
								del_d = IDX_W'(del_ext);
								idx_d = CNT_W'(del_ext + CMP_W'(1));
								state_d = ST_SHIFT;
							end else begin
								res_d = make_evt(EV_DEL_IGNORED, '0, 1'b0, 4'd0, 5'(count_q));
								state_d = ST_FINISH;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (issue) begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
				cmp_vld_d = issue;
				cmp_idx_d = raddr;
				if (hit) begin
					cmp_vld_d = 1'b0;
					res_d = make_evt(EV_GRANTED, key_q, perr_q, 4'(cmp_idx_q), 5'(count_q));
					state_d = ST_FINISH;
				end else if (!issue && !cmp_vld_q) begin
					res_d = make_evt(EV_DENIED, key_q, perr_q, 4'd0, 5'(count_q));
					state_d = ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (issue) begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
				cmp_vld_d = issue;
				cmp_idx_d = IDX_W'(idx_q - 1'b1);
				waddr = cmp_idx_q;
				wdata = rd_q;
				we = cmp_vld_q;
				if (!issue && !cmp_vld_q) begin
					count_d = CNT_W'(count_q - 1'b1);
					res_d = make_evt(EV_DELETED, '0, 1'b0, 4'(del_q), 5'(count_d));
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (res_free) begin
					stat.res_valid = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			armed_q <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
			armed_q <= armed_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		key_q <= key_d;
		perr_q <= perr_d;
		del_q <= del_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	`WCT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "stored count exceeds table depth")
	`WCT_ASSERT_ALWAYS(a_no_write_in_search, !((state_q == ST_SEARCH) && we), "table written during search")
	`WCT_ASSERT_NEXT(a_result_returns_idle, stat.res_valid, state_q == ST_IDLE, "sequencer busy after result")

endmodule

>>> hdl/wiegand_card_access_table.sv
// A data pulse that does not end a frame leaves the block idle; an enroll, refusal or
// ignored delete goes straight to its result; a match walks the table at one entry a
// cycle until a hit or the last stored entry; a delete moves each later entry down one
// slot, one entry a cycle. Data pulses are taken at one a cycle while the block is idle.
// A frame end or delete holds off beats until its result, held for a free output, shows;
// a beat is taken in that same cycle. Reset clears frame, count, arm, state and valid only.
module wiegand_card_access_table #(
	parameter int TABLE_DEPTH = wct_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input wct_pkg::cmd_t cmd,
	output logic evt_valid,
	input logic evt_ready,
	output wct_pkg::evt_t evt
);
	import wct_pkg::*;

	logic accept;
	logic pulse;
	logic res_free;
	logic evt_valid_q;
	evt_t evt_q;
	frame_t frame;
	op_t op;
	seq_stat_t stat;
	evt_t res;

	assign accept = cmd_valid && cmd_ready;
	assign pulse = accept && ((cmd.command == CMD_DATA0) || (cmd.command == CMD_DATA1));
	assign cmd_ready = stat.idle;
	assign res_free = !evt_valid_q || evt_ready;

	wct_frame_rx u_frame_rx (
		.clk(clk),
		.arst_n(arst_n),
		.pulse(pulse),
		.bit_in(cmd.command[0]),
		.frame(frame)
	);

	always_comb begin
		op.go = 1'b0;
		op.kind = OP_FRAME;
		op.key = frame.key;
		op.perr = frame.perr;
		op.del_idx = cmd.delete_index;
		case (cmd.command)
			CMD_ARM: begin
				op.go = accept;
				op.kind = OP_ARM;
			end
			CMD_DELETE: begin
				op.go = accept;
				op.kind = OP_DELETE;
			end
			default: begin
				op.go = frame.done;
			end
		endcase
	end

	wct_table_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table_seq (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.res_free(res_free),
		.stat(stat),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (stat.res_valid) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			evt_q <= res;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt = evt_q;

endmodule

>>> tb/sv/tb_wiegand_card_access_table.sv
`timescale 1ns / 100ps

module tb_wiegand_card_access_table;
	import wct_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int FRAME_BITS = 26;
	localparam int POOL_SIZE = 12;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic evt_valid;
	logic evt_ready;
	evt_t evt;

	wiegand_card_access_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt)
	);

	cmd_t pending_cmds[$];
	evt_t expected_events[$];

	int rx_bit_pos;
	logic [7:0] rx_facility;
	logic [15:0] rx_number;
	logic rx_lead;
	logic rx_xor_lo;
	logic rx_xor_hi;
	logic [23:0] whitelist [DEPTH];
	int whitelist_count;
	bit enroll_pending;

	int cycle_count;
	int beats_taken;
	int fail_count;
	int gen_items;
	int gen_bits;
	int hold_left;
	bit hold_done;
	bit cmd_taken;
	logic [23:0] card_pool [POOL_SIZE];

	function automatic evt_t make_event(input event_t ev, input logic [23:0] key,
			input logic perr, input int slot_idx);
		evt_t e;
		e.event_res = ev;
		e.facility_code = key[23:16];
		e.card_number = key[15:0];
		e.parity_error = perr;
		e.slot = 4'(slot_idx);
		e.entry_count = 5'(whitelist_count);
		return e;
	endfunction

	function automatic void apply_reader_beat(input cmd_t c);
		logic b;
		logic [23:0] key;
		logic perr;
		int hit;
		if (c.command == CMD_ARM) begin
			enroll_pending = 1;
		end else if (c.command == CMD_DELETE) begin
			if (int'(c.delete_index) < whitelist_count) begin
				for (int k = c.delete_index; k + 1 < whitelist_count; k++)
					whitelist[k] = whitelist[k + 1];
				whitelist_count--;
				expected_events.push_back(make_event(EV_DELETED, '0, 1'b0, c.delete_index));
			end else begin
				expected_events.push_back(make_event(EV_DEL_IGNORED, '0, 1'b0, 0));
			end
		end else begin
			b = c.command[0];
			if (rx_bit_pos == 0) begin
				rx_lead = b;
			end else if (rx_bit_pos < int'(NUMBER_START)) begin
				rx_facility = {rx_facility[6:0], b};
				rx_xor_lo ^= b;
			end else if (rx_bit_pos < int'(LAST_BIT)) begin
				rx_number = {rx_number[14:0], b};
				if (rx_bit_pos <= int'(FIRST_HALF_END))
					rx_xor_lo ^= b;
				else
					rx_xor_hi ^= b;
			end
			if (rx_bit_pos < int'(LAST_BIT)) begin
				rx_bit_pos++;
				return;
			end
			key = {rx_facility, rx_number};
			perr = (rx_lead ^ rx_xor_lo) | ~(rx_xor_hi ^ b);
			rx_bit_pos = 0;
			rx_facility = '0;
			rx_number = '0;
			rx_lead = 0;
			rx_xor_lo = 0;
			rx_xor_hi = 0;
			if (enroll_pending) begin
				enroll_pending = 0;
				if (whitelist_count < DEPTH) begin
					whitelist[whitelist_count] = key;
					whitelist_count++;
					expected_events.push_back(make_event(EV_ENROLLED, key, perr,
						whitelist_count - 1));
				end else begin
					expected_events.push_back(make_event(EV_REFUSED, key, perr, 0));
				end
			end else begin
				hit = -1;
				for (int k = 0; k < whitelist_count; k++)
					if (hit < 0 && whitelist[k] == key)
						hit = k;
				if (hit >= 0)
					expected_events.push_back(make_event(EV_GRANTED, key, perr, hit));
				else
					expected_events.push_back(make_event(EV_DENIED, key, perr, 0));
			end
		end
	endfunction

	function automatic void check_event(input evt_t got, input evt_t want);
		if (got.event_res !== want.event_res) begin
			$display("%0t: event_res expected %0d got %0d", $time, want.event_res,
				got.event_res);
			fail_count++;
		end
		if (got.facility_code !== want.facility_code) begin
			$display("%0t: facility_code expected %0d got %0d", $time,
				want.facility_code, got.facility_code);
			fail_count++;
		end
		if (got.card_number !== want.card_number) begin
			$display("%0t: card_number expected %0d got %0d", $time, want.card_number,
				got.card_number);
			fail_count++;
		end
		if (got.parity_error !== want.parity_error) begin
			$display("%0t: parity_error expected %0d got %0d", $time,
				want.parity_error, got.parity_error);
			fail_count++;
		end
		if (got.slot !== want.slot) begin
			$display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
			fail_count++;
		end
		if (got.entry_count !== want.entry_count) begin
			$display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
				got.entry_count);
			fail_count++;
		end
	endfunction

	task automatic push_cmd(input cmd_code_t op, input logic [3:0] idx);
		cmd_t c;
		c.command = op;
		c.delete_index = idx;
		pending_cmds.push_back(c);
		gen_items++;
		if (op == CMD_DATA0 || op == CMD_DATA1)
			gen_bits = (gen_bits + 1) % FRAME_BITS;
	endtask

	// Parity mode bit 0 corrupts the leading parity bit and bit 1 the trailing one.
	task automatic push_frame(input logic [23:0] key, input int parity_mode,
			input int mid_at, input cmd_code_t mid_op);
		logic [25:0] bits;
		while (gen_bits != 0)
			push_cmd($urandom_range(1) ? CMD_DATA1 : CMD_DATA0, 4'($urandom));
		bits[24:1] = key;
		bits[25] = (^key[23:12]) ^ parity_mode[0];
		bits[0] = (~^key[11:0]) ^ parity_mode[1];
		for (int i = 0; i < FRAME_BITS; i++) begin
			if (i == mid_at)
				push_cmd(mid_op, 4'($urandom));
			push_cmd(bits[25 - i] ? CMD_DATA1 : CMD_DATA0, 4'($urandom));
		end
	endtask

	task automatic push_random_frame(input logic [23:0] key);
		int mid_at;
		mid_at = ($urandom_range(99) < 10) ? int'($urandom_range(25)) : -1;
		push_frame(key, ($urandom_range(99) < 15) ? int'($urandom_range(1, 3)) : 0,
			mid_at, $urandom_range(1) ? CMD_DELETE : CMD_ARM);
	endtask

	task automatic push_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			push_cmd($urandom_range(1) ? CMD_DATA1 : CMD_DATA0, 4'($urandom));
	endtask

	task automatic build_stimulus();
		int r;
		logic [23:0] key;
		card_pool[0] = 24'h000000;
		card_pool[1] = 24'hFFFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			card_pool[i] = 24'($urandom);

		push_cmd(CMD_DELETE, 4'd0);
		push_cmd(CMD_DELETE, 4'd15);
		push_frame(24'hFFFFFF, 0, 13, CMD_DELETE);
		push_cmd(CMD_ARM, 4'd0);
		push_cmd(CMD_ARM, 4'd15);
		push_frame(24'h000000, 0, -1, CMD_ARM);
		push_frame(24'hFFFFFF, 1, 20, CMD_ARM);
		push_frame(24'hFFFFFF, 2, -1, CMD_ARM);
		push_cmd(CMD_DELETE, 4'd0);
		push_frame(24'hFFFFFF, 3, -1, CMD_ARM);
		push_frame(24'h000000, 0, -1, CMD_ARM);

		// The first half mostly enrolls so that the table fills and refusals occur.
		while (gen_items < 1350) begin
			r = $urandom_range(99);
			key = ($urandom_range(99) < 60) ? card_pool[$urandom_range(POOL_SIZE - 1)]
				: 24'($urandom);
			if (gen_items < 700) begin
				if (r < 78) begin
					push_cmd(CMD_ARM, 4'($urandom));
					push_random_frame(key);
				end else if (r < 88) begin
					push_random_frame(card_pool[$urandom_range(POOL_SIZE - 1)]);
				end else if (r < 93) begin
					push_cmd(CMD_DELETE, 4'($urandom));
				end else if (r < 96) begin
					push_cmd(CMD_ARM, 4'($urandom));
				end else begin
					push_noise();
				end
			end else begin
				if (r < 35) begin
					push_random_frame(card_pool[$urandom_range(POOL_SIZE - 1)]);
				end else if (r < 48) begin
					push_random_frame(24'($urandom));
				end else if (r < 60) begin
					push_cmd(CMD_ARM, 4'($urandom));
					push_random_frame(key);
				end else if (r < 88) begin
					push_cmd(CMD_DELETE, 4'($urandom));
				end else if (r < 92) begin
					push_cmd(CMD_ARM, 4'($urandom));
				end else begin
					push_noise();
				end
			end
		end
	endtask

	function automatic bit idling_allowed();
		return !(cycle_count >= 1500 && cycle_count < 2500);
	endfunction

	initial begin
		clk = 0;
	end

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (!arst_n) begin
			cmd_taken = 0;
		end else begin
			cmd_taken = cmd_valid && cmd_ready;
			if (cmd_taken) begin
				apply_reader_beat(cmd);
				beats_taken++;
			end
			if (evt_valid && evt_ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %p", $time, evt);
					fail_count++;
				end else begin
					check_event(evt, expected_events.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_taken) begin
				if (pending_cmds.size() > 0 &&
						!(idling_allowed() && $urandom_range(99) < 35)) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// A long receiver hold-off lets the sender back up against a stalled block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				evt_ready <= 1'b0;
			end else if (!hold_done && beats_taken >= 900) begin
				hold_done = 1;
				hold_left = 400;
				evt_ready <= 1'b0;
			end else begin
				evt_ready <= !(idling_allowed() && $urandom_range(99) < 35);
			end
		end
	end

	initial begin
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		evt_ready = 0;
		cycle_count = 0;
		beats_taken = 0;
		fail_count = 0;
		gen_items = 0;
		gen_bits = 0;
		hold_left = 0;
		hold_done = 0;
		cmd_taken = 0;
		rx_bit_pos = 0;
		rx_facility = '0;
		rx_number = '0;
		rx_lead = 0;
		rx_xor_lo = 0;
		rx_xor_hi = 0;
		whitelist_count = 0;
		enroll_pending = 0;
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() > 0 || cmd_valid)
			@(posedge clk);
		while (expected_events.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> wiegand_card_access_table.f
+incdir+hdl
hdl/wct_pkg.sv
hdl/wct_frame_rx.sv
hdl/wct_table_seq.sv
hdl/wiegand_card_access_table.sv
tb/sv/tb_wiegand_card_access_table.sv
